[hw/rtl/pnl_pkg.sv]
// ----------------------------------------------------------------------------
// pnl_pkg
// Shared constants, codes and controller-to-datapath command type for the
// periodic neighbour list engine.
// ----------------------------------------------------------------------------
package pnl_pkg;

    localparam int PNL_MAX_PARTICLES = 64;
    localparam int PNL_COORD_BITS    = 20;

    localparam int CFG_DATA_W = 42;
    localparam int CFG_IDX_W  = 3;
    localparam int BOX_W      = 20;
    localparam int CUT_W      = 42;
    localparam int SLOT_CFG_W = 7;
    localparam int IDX_PORT_W = 6;
    localparam int CNT_PORT_W = 6;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;
    localparam logic [1:0] CMD_CHECK = 2'd3;

    localparam logic [1:0] MODE_LIST    = 2'd0;
    localparam logic [1:0] MODE_CONTACT = 2'd1;
    localparam logic [1:0] MODE_MOVE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_ON       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_CUTOFF_SQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_CUTOFF_SQ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MOVE_SQ       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_COUNT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT    = 3'd7;

    // Per-cycle commands from the controller to the datapath
    typedef struct packed {
        logic       wr_pos;     // store request position at addr
        logic       latch_a;    // capture reference particle from read data
        logic       snap_prev;  // copy read position into previous store
        logic       acc_clr;    // clear pair counter and row accumulator
        logic       issue;      // send pair (a, slot at addr) into the pipe
        logic       keep;       // pair qualifies (list and move modes)
        logic       row_load;   // load bitmap row shifter
        logic       row_zero;   // row is outside last build: load zeros
        logic       row_wr;     // write accumulated row at addr
        logic       emit;       // launch one result
        logic       emit_last;  // result closes the request
        logic [1:0] mode;       // MODE_LIST, MODE_CONTACT or MODE_MOVE
    } pnl_cmd_t;

endpackage

[hw/rtl/pnl_dpath.sv]
// ----------------------------------------------------------------------------
// pnl_dpath
// Position stores, bitmap store and the pipelined squared-distance unit with
// its counters and result registers.
// ----------------------------------------------------------------------------
module pnl_dpath #(
    parameter int MAX_PARTICLES = pnl_pkg::PNL_MAX_PARTICLES,
    parameter int COORD_BITS    = pnl_pkg::PNL_COORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pnl_pkg::pnl_cmd_t                      cmd,
    input  logic [$clog2(MAX_PARTICLES)-1:0]       addr,
    input  logic [COORD_BITS-1:0]                  pos_x,
    input  logic [COORD_BITS-1:0]                  pos_y,
    input  logic [pnl_pkg::BOX_W-1:0]              box_width,
    input  logic [pnl_pkg::BOX_W-1:0]              box_height,
    input  logic                                   periodic_on,
    input  logic [pnl_pkg::CUT_W-1:0]              list_cutoff_sq,
    input  logic [pnl_pkg::CUT_W-1:0]              contact_cutoff_sq,
    input  logic [pnl_pkg::CUT_W-1:0]              max_move_sq,
    output logic                                   pipe_busy,
    output logic                                   result_valid,
    output logic [pnl_pkg::IDX_PORT_W-1:0]         result_index,
    output logic [pnl_pkg::CNT_PORT_W-1:0]         neighbour_count,
    output logic                                   rebuild_needed,
    output logic                                   last
);
    import pnl_pkg::*;

    localparam int IW    = $clog2(MAX_PARTICLES);
    localparam int NW    = $clog2(MAX_PARTICLES + 1);
    localparam int C     = COORD_BITS;
    localparam int W     = ((C > BOX_W) ? C : BOX_W) + 3;
    localparam int SQ_W  = 2 * C + 1;
    localparam int CMP_W = (SQ_W > CUT_W) ? SQ_W : CUT_W;
    localparam int ACC_X = (NW > CNT_PORT_W) ? NW : CNT_PORT_W;

    logic [C-1:0] cur_x_mem  [MAX_PARTICLES];
    logic [C-1:0] cur_y_mem  [MAX_PARTICLES];
    logic [C-1:0] prev_x_mem [MAX_PARTICLES];
    logic [C-1:0] prev_y_mem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] row_mem [MAX_PARTICLES];

    logic [C-1:0]             cur_x_q, cur_y_q, prev_x_q, prev_y_q;
    logic [MAX_PARTICLES-1:0] row_q;

    logic [C-1:0]             ax_reg, ay_reg;
    logic [MAX_PARTICLES-1:0] row_sh_reg, row_acc_reg;
    logic [NW-1:0]            acc_reg;

    logic                     v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]            tag1_reg, tag2_reg, tag3_reg;
    logic [C-1:0]             dx_reg, dy_reg;
    logic [2*C-1:0]           sqx_reg, sqy_reg;

    logic                     keep_eff;
    logic [C-1:0]             ref_x, ref_y, dx_abs, dy_abs;
    logic [CMP_W-1:0]         sum_ext;
    logic                     hit;

    logic                     valid_reg;
    logic [IDX_PORT_W-1:0]    index_reg;
    logic [CNT_PORT_W-1:0]    count_reg;
    logic                     flag_reg, last_reg;

    function automatic logic [C-1:0] wrap_abs(
        input logic [C-1:0]     a,
        input logic [C-1:0]     b,
        input logic [BOX_W-1:0] len,
        input logic             per
    );
        logic signed [W-1:0] d;
        logic signed [W-1:0] l;
        logic signed [W-1:0] t;
        d = $signed(W'(b)) - $signed(W'(a));
        l = $signed(W'(len));
        t = d;
        if (per)
        begin
            if ((d <<< 1) > l)
                t = d - l;
            else if ((d <<< 1) < -l)
                t = d + l;
        end
        if (t < 0)
            t = -t;
        return C'(t);
    endfunction

    // Stores: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_pos)
        begin
            cur_x_mem[addr] <= pos_x;
            cur_y_mem[addr] <= pos_y;
        end
        cur_x_q <= cur_x_mem[addr];
        cur_y_q <= cur_y_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap_prev)
        begin
            prev_x_mem[addr] <= cur_x_q;
            prev_y_mem[addr] <= cur_y_q;
        end
        prev_x_q <= prev_x_mem[addr];
        prev_y_q <= prev_y_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_wr)
            row_mem[addr] <= row_acc_reg;
        row_q <= row_mem[addr];
    end

    assign keep_eff = (cmd.mode == MODE_CONTACT) ? row_sh_reg[0] : cmd.keep;
    assign ref_x    = (cmd.mode == MODE_MOVE) ? prev_x_q : ax_reg;
    assign ref_y    = (cmd.mode == MODE_MOVE) ? prev_y_q : ay_reg;
    assign dx_abs   = wrap_abs(ref_x, cur_x_q, box_width, periodic_on);
    assign dy_abs   = wrap_abs(ref_y, cur_y_q, box_height, periodic_on);
    assign sum_ext  = CMP_W'(SQ_W'(sqx_reg) + SQ_W'(sqy_reg));

    always_comb
    begin
        case (cmd.mode)
            MODE_LIST:    hit = sum_ext < CMP_W'(list_cutoff_sq);
            MODE_CONTACT: hit = sum_ext < CMP_W'(contact_cutoff_sq);
            MODE_MOVE:    hit = sum_ext > CMP_W'(max_move_sq);
            default:      hit = 1'b0;
        endcase
    end

    // Payload-only pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_a)
        begin
            ax_reg <= cur_x_q;
            ay_reg <= cur_y_q;
        end
        if (cmd.row_load)
            row_sh_reg <= cmd.row_zero ? '0 : row_q;
        else if (cmd.issue)
            row_sh_reg <= row_sh_reg >> 1;
        tag1_reg <= addr;
        tag2_reg <= tag1_reg;
        tag3_reg <= tag2_reg;
        dx_reg   <= dx_abs;
        dy_reg   <= dy_abs;
        sqx_reg  <= (2*C)'(dx_reg) * (2*C)'(dx_reg);
        sqy_reg  <= (2*C)'(dy_reg) * (2*C)'(dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue & keep_eff;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign pipe_busy = v1_reg | v2_reg | v3_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg     <= '0;
            row_acc_reg <= '0;
        end
        else if (v3_reg && hit)
        begin
            acc_reg               <= acc_reg + NW'(1);
            row_acc_reg[tag3_reg] <= 1'b1;
        end
    end

    // Result registers: strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_reg <= cmd.emit_last;
            if (cmd.mode == MODE_MOVE)
            begin
                index_reg <= '0;
                count_reg <= '0;
                flag_reg  <= (acc_reg != '0);
            end
            else
            begin
                index_reg <= IDX_PORT_W'(addr);
                count_reg <= (ACC_X'(acc_reg) > ACC_X'(63)) ? CNT_PORT_W'(63)
                                                            : CNT_PORT_W'(acc_reg);
                flag_reg  <= 1'b0;
            end
        end
    end

    assign result_valid    = valid_reg;
    assign result_index    = index_reg;
    assign neighbour_count = count_reg;
    assign rebuild_needed  = flag_reg;
    assign last            = last_reg;

endmodule

[hw/rtl/pnl_ctrl.sv]
// ----------------------------------------------------------------------------
// pnl_ctrl
// Request sequencer: walks particle pairs for build, count and check and
// issues per-cycle commands to the datapath.
// ----------------------------------------------------------------------------
module pnl_ctrl #(
    parameter int MAX_PARTICLES = pnl_pkg::PNL_MAX_PARTICLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          command,
    input  logic [pnl_pkg::IDX_PORT_W-1:0]      particle_index,
    input  logic [pnl_pkg::SLOT_CFG_W-1:0]      boundary_count,
    input  logic [pnl_pkg::SLOT_CFG_W-1:0]      particle_count,
    input  logic                                pipe_busy,
    output logic                                busy,
    output pnl_pkg::pnl_cmd_t                   cmd,
    output logic [$clog2(MAX_PARTICLES)-1:0]    addr
);
    import pnl_pkg::*;

    localparam int IW = $clog2(MAX_PARTICLES);
    localparam int NW = $clog2(MAX_PARTICLES + 1);
    localparam int NE = (NW > SLOT_CFG_W) ? NW : SLOT_CFG_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_B_LOAD  = 4'd1;
    localparam logic [3:0] S_B_LATCH = 4'd2;
    localparam logic [3:0] S_B_SCAN  = 4'd3;
    localparam logic [3:0] S_B_DRAIN = 4'd4;
    localparam logic [3:0] S_C_LATCH = 4'd5;
    localparam logic [3:0] S_C_SCAN  = 4'd6;
    localparam logic [3:0] S_C_DRAIN = 4'd7;
    localparam logic [3:0] S_K_SCAN  = 4'd8;
    localparam logic [3:0] S_K_DRAIN = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [NE-1:0] i_reg, i_next, j_reg, j_next, lim_reg, lim_next;
    logic [NE-1:0] bnd_snap_reg, bnd_snap_next, n_snap_reg, n_snap_next;
    logic          built_reg, built_next;
    logic [1:0]    mode_reg, mode_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic [IW-1:0] idx_tab [64];
    logic [IW-1:0] idx_map;
    logic [NE-1:0] bnd_w, n_w;
    logic          row_ok;

    // Fold the request index onto the slot range
    for (genvar k = 0; k < 64; k++)
    begin : g_idx_tab
        assign idx_tab[k] = IW'(k % MAX_PARTICLES);
    end

    assign idx_map = idx_tab[particle_index];
    assign bnd_w   = NE'(boundary_count);
    assign n_w     = (NE'(particle_count) > NE'(MAX_PARTICLES)) ? NE'(MAX_PARTICLES)
                                                                : NE'(particle_count);
    assign row_ok  = built_reg && (NE'(idx_reg) >= bnd_snap_reg)
                               && (NE'(idx_reg) < n_snap_reg);
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        lim_next      = lim_reg;
        bnd_snap_next = bnd_snap_reg;
        n_snap_next   = n_snap_reg;
        built_next    = built_reg;
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.mode      = mode_reg;
        addr          = i_reg[IW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                addr = idx_map;
                if (start)
                begin
                    case (command)
                        CMD_WRITE:
                            cmd.wr_pos = 1'b1;
                        CMD_BUILD:
                        begin
                            bnd_snap_next = bnd_w;
                            n_snap_next   = n_w;
                            built_next    = 1'b1;
                            lim_next      = n_w;
                            mode_next     = MODE_LIST;
                            i_next        = bnd_w;
                            if (bnd_w < n_w)
                                state_next = S_B_LOAD;
                        end
                        CMD_COUNT:
                        begin
                            idx_next   = idx_map;
                            mode_next  = MODE_CONTACT;
                            state_next = S_C_LATCH;
                        end
                        CMD_CHECK:
                        begin
                            mode_next   = MODE_MOVE;
                            cmd.acc_clr = 1'b1;
                            i_next      = bnd_w;
                            lim_next    = n_w;
                            state_next  = (bnd_w < n_w) ? S_K_SCAN : S_K_DRAIN;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_B_LOAD:
                state_next = S_B_LATCH;
            S_B_LATCH:
            begin
                cmd.latch_a   = 1'b1;
                cmd.snap_prev = 1'b1;
                cmd.acc_clr   = 1'b1;
                j_next        = '0;
                state_next    = S_B_SCAN;
            end
            S_B_SCAN:
            begin
                addr      = j_reg[IW-1:0];
                cmd.issue = 1'b1;
                cmd.keep  = (j_reg != i_reg);
                if (j_reg == lim_reg - NE'(1))
                    state_next = S_B_DRAIN;
                else
                    j_next = j_reg + NE'(1);
            end
            S_B_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    cmd.row_wr    = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = (i_reg + NE'(1) == lim_reg);
                    if (i_reg + NE'(1) == lim_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + NE'(1);
                        state_next = S_B_LOAD;
                    end
                end
            end
            S_C_LATCH:
            begin
                cmd.latch_a  = 1'b1;
                cmd.row_load = 1'b1;
                cmd.row_zero = !row_ok;
                cmd.acc_clr  = 1'b1;
                j_next       = '0;
                state_next   = S_C_SCAN;
            end
            S_C_SCAN:
            begin
                addr      = j_reg[IW-1:0];
                cmd.issue = 1'b1;
                cmd.keep  = 1'b1;
                if (j_reg == NE'(MAX_PARTICLES - 1))
                    state_next = S_C_DRAIN;
                else
                    j_next = j_reg + NE'(1);
            end
            S_C_DRAIN:
            begin
                addr = idx_reg;
                if (!pipe_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_K_SCAN:
            begin
                cmd.issue = 1'b1;
                cmd.keep  = 1'b1;
                if (i_reg == lim_reg - NE'(1))
                    state_next = S_K_DRAIN;
                else
                    i_next = i_reg + NE'(1);
            end
            S_K_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            lim_reg      <= '0;
            bnd_snap_reg <= '0;
            n_snap_reg   <= '0;
            built_reg    <= 1'b0;
            mode_reg     <= MODE_LIST;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            lim_reg      <= lim_next;
            bnd_snap_reg <= bnd_snap_next;
            n_snap_reg   <= n_snap_next;
            built_reg    <= built_next;
            mode_reg     <= mode_next;
            idx_reg      <= idx_next;
        end
    end

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmd.issue)
        else $error("pair issued while idle");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !pipe_busy)
        else $error("result launched with pairs in flight");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B_SCAN) |-> (j_reg < lim_reg))
        else $error("build scan past slot limit");

    a_emit_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> ((state_reg == S_IDLE) || (state_reg == S_B_LOAD)))
        else $error("unexpected state after result");

endmodule

[hw/rtl/periodic_neighbour_list_engine_top.sv]
// ----------------------------------------------------------------------------
// periodic_neighbour_list_engine_top
// 2-D particle store with periodic Verlet neighbour list build, contact count
// and rebuild check.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; results leave on
// result_valid for exactly one cycle each and cannot be held off, so capture
// them every cycle. A build scans every slot in use for each mobile particle,
// since the single distance pipeline checks one pair per cycle, and each
// particle's row drains before its result; one result per mobile particle.
// A count scans all MAX_PARTICLES slots; a check scans the mobile particles.
// No clearing pass is needed after reset: bitmap rows outside the last build
// read as empty.
// ----------------------------------------------------------------------------
module periodic_neighbour_list_engine_top #(
    parameter int MAX_PARTICLES = pnl_pkg::PNL_MAX_PARTICLES,
    parameter int COORD_BITS    = pnl_pkg::PNL_COORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           command,
    input  logic [pnl_pkg::IDX_PORT_W-1:0]       particle_index,
    input  logic [COORD_BITS-1:0]                pos_x,
    input  logic [COORD_BITS-1:0]                pos_y,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [pnl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pnl_pkg::CFG_DATA_W-1:0]       cfg_data,
    // result channel
    output logic                                 result_valid,
    output logic [pnl_pkg::IDX_PORT_W-1:0]       result_index,
    output logic [pnl_pkg::CNT_PORT_W-1:0]       neighbour_count,
    output logic                                 rebuild_needed,
    output logic                                 last
);
    import pnl_pkg::*;

    localparam int IW = $clog2(MAX_PARTICLES);

    logic [BOX_W-1:0]      box_width_reg, box_height_reg;
    logic                  periodic_on_reg;
    logic [CUT_W-1:0]      list_cut_reg, contact_cut_reg, max_move_reg;
    logic [SLOT_CFG_W-1:0] boundary_reg, particle_reg;

    pnl_cmd_t              cmd;
    logic [IW-1:0]         addr;
    logic                  pipe_busy;

    // Configuration registers: the user must write them only between requests; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg   <= {BOX_W{1'b1}};
            box_height_reg  <= {BOX_W{1'b1}};
            periodic_on_reg <= 1'b0;
            list_cut_reg    <= '0;
            contact_cut_reg <= '0;
            max_move_reg    <= '0;
            boundary_reg    <= '0;
            particle_reg    <= SLOT_CFG_W'(64);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BOX_WIDTH:         box_width_reg   <= cfg_data[BOX_W-1:0];
                REG_BOX_HEIGHT:        box_height_reg  <= cfg_data[BOX_W-1:0];
                REG_PERIODIC_ON:       periodic_on_reg <= cfg_data[0];
                REG_LIST_CUTOFF_SQ:    list_cut_reg    <= cfg_data[CUT_W-1:0];
                REG_CONTACT_CUTOFF_SQ: contact_cut_reg <= cfg_data[CUT_W-1:0];
                REG_MAX_MOVE_SQ:       max_move_reg    <= cfg_data[CUT_W-1:0];
                REG_BOUNDARY_COUNT:    boundary_reg    <= cfg_data[SLOT_CFG_W-1:0];
                REG_PARTICLE_COUNT:    particle_reg    <= cfg_data[SLOT_CFG_W-1:0];
                default:               particle_reg    <= particle_reg;
            endcase
        end
    end

    // Sequencer: steps through slots and pairs
    pnl_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .particle_index (particle_index),
        .boundary_count (boundary_reg),
        .particle_count (particle_reg),
        .pipe_busy      (pipe_busy),
        .busy           (busy),
        .cmd            (cmd),
        .addr           (addr)
    );

    // Stores, distance pipeline and result registers
    pnl_dpath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .COORD_BITS    (COORD_BITS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .addr              (addr),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .box_width         (box_width_reg),
        .box_height        (box_height_reg),
        .periodic_on       (periodic_on_reg),
        .list_cutoff_sq    (list_cut_reg),
        .contact_cutoff_sq (contact_cut_reg),
        .max_move_sq       (max_move_reg),
        .pipe_busy         (pipe_busy),
        .result_valid      (result_valid),
        .result_index      (result_index),
        .neighbour_count   (neighbour_count),
        .rebuild_needed    (rebuild_needed),
        .last              (last)
    );

endmodule
